### src/gn_pkg.sv
package gn_pkg;

    localparam int GN_TABLE_SIZE = 256;

    localparam logic [1:0] OP_EVAL = 2'd0;
    localparam logic [1:0] OP_PERM = 2'd1;
    localparam logic [1:0] OP_GRAD = 2'd2;

    typedef struct packed {
        logic signed [15:0] gx;
        logic signed [15:0] gy;
    } t_grad;

    typedef struct packed {
        logic        valid;
        t_grad       g00;
        t_grad       g10;
        t_grad       g01;
        t_grad       g11;
        logic [15:0] fx;
        logic [15:0] fy;
    } t_corners;

    function automatic logic signed [33:0] dot2(t_grad g, logic signed [16:0] ox,
                                                logic signed [16:0] oy);
        logic signed [33:0] a;
        logic signed [33:0] b;
        a = 34'(g.gx) * 34'(ox);
        b = 34'(g.gy) * 34'(oy);
        return a + b;
    endfunction

endpackage

### src/gn_fade.sv
module gn_fade import gn_pkg::*; (
    input  logic        i_clk,
    input  logic [15:0] i_f,
    output logic [16:0] o_u
);

    logic [15:0] r_f1;
    logic [16:0] r_t2;
    logic [16:0] r_t3;
    logic [19:0] r_in;
    logic [16:0] r_u;
    logic [32:0] sq;
    logic [32:0] cube;
    logic [21:0] poly;
    logic [36:0] prod;

    assign sq   = 33'(i_f) * 33'(i_f) + 33'd32768;
    assign cube = 33'(r_t2) * 33'(r_f1) + 33'd32768;
    assign poly = 22'd655360 - 22'(r_f1) * 22'd15 + 22'(r_t2) * 22'd6;
    assign prod = 37'(r_t3) * 37'(r_in) + 37'd32768;

    always_ff @(posedge i_clk) begin
        r_f1 <= i_f;
        r_t2 <= sq[32:16];
        r_t3 <= cube[32:16];
        r_in <= poly[19:0];
        r_u  <= prod[32:16];
    end

    assign o_u = r_u;

endmodule

### src/gn_lattice.sv
module gn_lattice import gn_pkg::*; #(
    parameter int TABLE_SIZE = GN_TABLE_SIZE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [1:0]                    i_op,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_xi,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_yi,
    input  logic                          i_wr_ok,
    input  logic [7:0]                    i_wr_idx,
    input  logic [7:0]                    i_perm_value,
    input  t_grad                         i_grad,
    input  logic [15:0]                   i_fx,
    input  logic [15:0]                   i_fy,
    output t_corners                      o_corners
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    logic [7:0] r_p1_mem [TABLE_SIZE];
    logic [7:0] r_p2_mem [TABLE_SIZE];
    logic [7:0] r_p3_mem [TABLE_SIZE];
    t_grad      r_g1_mem [TABLE_SIZE];
    t_grad      r_g2_mem [TABLE_SIZE];

    logic [10:0]      wr_ext;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] xi1;

    // Stage B: first-level permutation values and the item's fields.
    logic             r_b_valid;
    logic [1:0]       r_b_op;
    logic             r_b_wr_ok;
    logic [IDX_W-1:0] r_b_waddr;
    logic [7:0]       r_b_perm;
    t_grad            r_b_grad;
    logic [IDX_W-1:0] r_b_yi;
    logic [15:0]      r_b_fx;
    logic [15:0]      r_b_fy;
    logic [7:0]       r_pa;
    logic [7:0]       r_pb;

    logic [10:0]      sum_a;
    logic [10:0]      sum_b;
    logic [IDX_W-1:0] a0;
    logic [IDX_W-1:0] a1;
    logic [IDX_W-1:0] b0;
    logic [IDX_W-1:0] b1;

    // Stage C: corner hashes.
    logic             r_c_valid;
    logic [1:0]       r_c_op;
    logic             r_c_wr_ok;
    logic [IDX_W-1:0] r_c_waddr;
    t_grad            r_c_grad;
    logic [15:0]      r_c_fx;
    logic [15:0]      r_c_fy;
    logic [7:0]       r_h00;
    logic [7:0]       r_h01;
    logic [7:0]       r_h10;
    logic [7:0]       r_h11;

    logic [10:0]      e00;
    logic [10:0]      e01;
    logic [10:0]      e10;
    logic [10:0]      e11;

    // Stage D: corner gradients.
    logic             r_d_valid;
    logic [15:0]      r_d_fx;
    logic [15:0]      r_d_fy;
    t_grad            r_g00;
    t_grad            r_g01;
    t_grad            r_g10;
    t_grad            r_g11;

    assign wr_ext = 11'(i_wr_idx);
    assign waddr  = wr_ext[IDX_W-1:0];
    assign xi1    = i_xi + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_valid && i_op == OP_PERM && i_wr_ok) begin
            r_p1_mem[waddr] <= i_perm_value;
        end
        r_pa      <= r_p1_mem[i_xi];
        r_pb      <= r_p1_mem[xi1];
        r_b_op    <= i_op;
        r_b_wr_ok <= i_wr_ok;
        r_b_waddr <= waddr;
        r_b_perm  <= i_perm_value;
        r_b_grad  <= i_grad;
        r_b_yi    <= i_yi;
        r_b_fx    <= i_fx;
        r_b_fy    <= i_fy;
    end

    assign sum_a = 11'(r_pa) + 11'(r_b_yi);
    assign sum_b = 11'(r_pb) + 11'(r_b_yi);
    assign a0    = sum_a[IDX_W-1:0];
    assign a1    = a0 + 1'b1;
    assign b0    = sum_b[IDX_W-1:0];
    assign b1    = b0 + 1'b1;

    always_ff @(posedge i_clk) begin
        if (r_b_valid && r_b_op == OP_PERM && r_b_wr_ok) begin
            r_p2_mem[r_b_waddr] <= r_b_perm;
            r_p3_mem[r_b_waddr] <= r_b_perm;
        end
        r_h00     <= r_p2_mem[a0];
        r_h01     <= r_p2_mem[a1];
        r_h10     <= r_p3_mem[b0];
        r_h11     <= r_p3_mem[b1];
        r_c_op    <= r_b_op;
        r_c_wr_ok <= r_b_wr_ok;
        r_c_waddr <= r_b_waddr;
        r_c_grad  <= r_b_grad;
        r_c_fx    <= r_b_fx;
        r_c_fy    <= r_b_fy;
    end

    assign e00 = 11'(r_h00);
    assign e01 = 11'(r_h01);
    assign e10 = 11'(r_h10);
    assign e11 = 11'(r_h11);

    always_ff @(posedge i_clk) begin
        if (r_c_valid && r_c_op == OP_GRAD && r_c_wr_ok) begin
            r_g1_mem[r_c_waddr] <= r_c_grad;
            r_g2_mem[r_c_waddr] <= r_c_grad;
        end
        r_g00  <= r_g1_mem[e00[IDX_W-1:0]];
        r_g10  <= r_g1_mem[e10[IDX_W-1:0]];
        r_g01  <= r_g2_mem[e01[IDX_W-1:0]];
        r_g11  <= r_g2_mem[e11[IDX_W-1:0]];
        r_d_fx <= r_c_fx;
        r_d_fy <= r_c_fy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_b_valid <= i_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid && r_c_op == OP_EVAL;
        end
    end

    assign o_corners.valid = r_d_valid;
    assign o_corners.g00   = r_g00;
    assign o_corners.g10   = r_g10;
    assign o_corners.g01   = r_g01;
    assign o_corners.g11   = r_g11;
    assign o_corners.fx    = r_d_fx;
    assign o_corners.fy    = r_d_fy;

endmodule

### src/gn_blend.sv
module gn_blend import gn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_corners           i_corners,
    input  logic [16:0]        i_u,
    input  logic [16:0]        i_v,
    output logic               o_valid,
    output logic signed [15:0] o_noise
);

    logic signed [16:0] ox0;
    logic signed [16:0] ox1;
    logic signed [16:0] oy0;
    logic signed [16:0] oy1;

    logic               r_valid1;
    logic               r_valid2;
    logic               r_valid3;
    logic               r_valid4;
    logic               r_valid5;
    logic signed [33:0] r_d00;
    logic signed [33:0] r_d10;
    logic signed [33:0] r_d01;
    logic signed [33:0] r_d11;
    logic [16:0]        r_u1;
    logic [16:0]        r_v1;
    logic [16:0]        r_v2;
    logic [16:0]        r_v3;
    logic signed [33:0] r_d00_2;
    logic signed [33:0] r_d01_2;
    logic signed [52:0] r_m0;
    logic signed [52:0] r_m1;
    logic signed [36:0] r_r0;
    logic signed [36:0] r_r1;
    logic signed [36:0] r_r0_4;
    logic signed [55:0] r_m2;
    logic signed [15:0] r_noise;

    logic signed [52:0] q0;
    logic signed [52:0] q1;
    logic signed [55:0] q2;
    logic signed [37:0] s;
    logic signed [37:0] sr;
    logic signed [37:0] n;
    logic signed [15:0] n_noise;

    assign ox0 = $signed({1'b0, i_corners.fx});
    assign ox1 = $signed({1'b1, i_corners.fx});
    assign oy0 = $signed({1'b0, i_corners.fy});
    assign oy1 = $signed({1'b1, i_corners.fy});

    assign q0 = r_m0 + 53'sd32768;
    assign q1 = r_m1 + 53'sd32768;
    assign q2 = r_m2 + 56'sd32768;
    assign s  = 38'(r_r0_4) + 38'(q2 >>> 16);
    assign sr = s + 38'sd32768;
    assign n  = sr >>> 16;

    always_comb begin
        if (n > 38'sd32767) begin
            n_noise = 16'sh7fff;
        end else if (n < -38'sd32768) begin
            n_noise = 16'sh8000;
        end else begin
            n_noise = 16'(n);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d00   <= dot2(i_corners.g00, ox0, oy0);
        r_d10   <= dot2(i_corners.g10, ox1, oy0);
        r_d01   <= dot2(i_corners.g01, ox0, oy1);
        r_d11   <= dot2(i_corners.g11, ox1, oy1);
        r_u1    <= i_u;
        r_v1    <= i_v;
        r_m0    <= 53'(35'(r_d10) - 35'(r_d00)) * 53'($signed({1'b0, r_u1}));
        r_m1    <= 53'(35'(r_d11) - 35'(r_d01)) * 53'($signed({1'b0, r_u1}));
        r_d00_2 <= r_d00;
        r_d01_2 <= r_d01;
        r_v2    <= r_v1;
        r_r0    <= 37'(r_d00_2) + 37'(q0 >>> 16);
        r_r1    <= 37'(r_d01_2) + 37'(q1 >>> 16);
        r_v3    <= r_v2;
        r_m2    <= 56'(38'(r_r1) - 38'(r_r0)) * 56'($signed({1'b0, r_v3}));
        r_r0_4  <= r_r0;
        r_noise <= n_noise;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
            r_valid4 <= 1'b0;
            r_valid5 <= 1'b0;
        end else begin
            r_valid1 <= i_corners.valid;
            r_valid2 <= r_valid1;
            r_valid3 <= r_valid2;
            r_valid4 <= r_valid3;
            r_valid5 <= r_valid4;
        end
    end

    assign o_valid = r_valid5;
    assign o_noise = r_noise;

endmodule

### src/gradient_noise_2d.sv
// A result on o_noise_value comes only from an evaluate request accepted with start.
// The path has nine register stages: the input register, three table lookups, five blend steps.
// Throughput: one request per cycle; busy is always low and the pipeline never stalls.
// Table writes travel down the pipeline, so every request sees exactly the writes before it.
// Reset clears only the valid bits; table entries are undefined until written.
module gradient_noise_2d import gn_pkg::*; #(
    parameter int TABLE_SIZE = GN_TABLE_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic signed [23:0] i_coord_x,
    input  logic signed [23:0] i_coord_y,
    input  logic [7:0]         i_entry_index,
    input  logic [7:0]         i_perm_value,
    input  logic signed [15:0] i_grad_x,
    input  logic signed [15:0] i_grad_y,
    output logic               o_valid,
    output logic signed [15:0] o_noise_value
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int LAT   = 9;

    logic             accept;
    logic [10:0]      ix_ext;
    logic [10:0]      iy_ext;
    logic             r_valid;
    logic [1:0]       r_op;
    logic [15:0]      r_fx;
    logic [15:0]      r_fy;
    logic [IDX_W-1:0] r_xi;
    logic [IDX_W-1:0] r_yi;
    logic             r_wr_ok;
    logic [7:0]       r_idx;
    logic [7:0]       r_perm;
    t_grad            r_grad;
    logic [16:0]      u;
    logic [16:0]      v;
    t_corners         corners;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign ix_ext = {{3{i_coord_x[23]}}, i_coord_x[23:16]};
    assign iy_ext = {{3{i_coord_y[23]}}, i_coord_y[23:16]};

    always_ff @(posedge i_clk) begin
        r_op      <= i_op;
        r_fx      <= i_coord_x[15:0];
        r_fy      <= i_coord_y[15:0];
        r_xi      <= ix_ext[IDX_W-1:0];
        r_yi      <= iy_ext[IDX_W-1:0];
        r_wr_ok   <= 11'(i_entry_index) < 11'(TABLE_SIZE);
        r_idx     <= i_entry_index;
        r_perm    <= i_perm_value;
        r_grad.gx <= i_grad_x;
        r_grad.gy <= i_grad_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
    end

    gn_fade u_fade_x (
        .i_clk (i_clk),
        .i_f   (r_fx),
        .o_u   (u)
    );

    gn_fade u_fade_y (
        .i_clk (i_clk),
        .i_f   (r_fy),
        .o_u   (v)
    );

    gn_lattice #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_lattice (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_valid),
        .i_op         (r_op),
        .i_xi         (r_xi),
        .i_yi         (r_yi),
        .i_wr_ok      (r_wr_ok),
        .i_wr_idx     (r_idx),
        .i_perm_value (r_perm),
        .i_grad       (r_grad),
        .i_fx         (r_fx),
        .i_fy         (r_fy),
        .o_corners    (corners)
    );

    gn_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_corners (corners),
        .i_u       (u),
        .i_v       (v),
        .o_valid   (o_valid),
        .o_noise   (o_noise_value)
    );

    a_result_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept && i_op == OP_EVAL, LAT))
        else $error("result without an evaluate request");

    a_result_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_rst_n, LAT))
        else $error("result from a request taken during reset");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op != OP_EVAL) |-> ##LAT !o_valid)
        else $error("non-evaluate request produced a result");

endmodule

### test/noise_checker.sv
module noise_checker import gn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_op,
    input  logic signed [23:0] i_coord_x,
    input  logic signed [23:0] i_coord_y,
    input  logic [7:0]         i_entry_index,
    input  logic [7:0]         i_perm_value,
    input  logic signed [15:0] i_grad_x,
    input  logic signed [15:0] i_grad_y,
    input  logic               i_valid,
    input  logic signed [15:0] i_noise_value,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]         perm_copy [GN_TABLE_SIZE];
    t_grad              grad_copy [GN_TABLE_SIZE];
    logic signed [15:0] noise_expected [$];

    function automatic longint fade_weight(longint f);
        longint t2;
        longint t3;
        longint poly;
        t2 = (f * f + 32768) >>> 16;
        t3 = (t2 * f + 32768) >>> 16;
        poly = 10 * 65536 - 15 * f + 6 * t2;
        return (t3 * poly + 32768) >>> 16;
    endfunction

    function automatic longint round16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint mix(longint a, longint b, longint w);
        return a + round16((b - a) * w);
    endfunction

    function automatic longint corner_product(int cx, int cy, longint ox, longint oy);
        logic [7:0] h;
        t_grad      g;
        h = perm_copy[8'(perm_copy[cx] + cy)];
        g = grad_copy[h];
        return longint'(g.gx) * ox + longint'(g.gy) * oy;
    endfunction

    function automatic logic signed [15:0] noise_at(logic signed [23:0] x,
                                                    logic signed [23:0] y);
        longint ix;
        longint iy;
        longint fx;
        longint fy;
        longint u;
        longint v;
        longint d00;
        longint d10;
        longint d01;
        longint d11;
        longint n;
        int     x0;
        int     y0;
        int     x1;
        int     y1;
        ix = longint'(x) >>> 16;
        iy = longint'(y) >>> 16;
        fx = longint'(x) - ix * 65536;
        fy = longint'(y) - iy * 65536;
        x0 = int'(ix & 255);
        y0 = int'(iy & 255);
        x1 = (x0 + 1) & 255;
        y1 = (y0 + 1) & 255;
        u = fade_weight(fx);
        v = fade_weight(fy);
        d00 = corner_product(x0, y0, fx, fy);
        d10 = corner_product(x1, y0, fx - 65536, fy);
        d01 = corner_product(x0, y1, fx, fy - 65536);
        d11 = corner_product(x1, y1, fx - 65536, fy - 65536);
        n = round16(mix(mix(d00, d10, u), mix(d01, d11, u), v));
        if (n > 32767) n = 32767;
        if (n < -32768) n = -32768;
        return 16'(n);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            noise_expected.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid) begin
                if (noise_expected.size() == 0) begin
                    $display("%0t unexpected noise result: expected none actual %0d",
                             $time, i_noise_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    logic signed [15:0] want;
                    want = noise_expected.pop_front();
                    if (want !== i_noise_value) begin
                        $display("%0t noise_value mismatch: expected %0d actual %0d",
                                 $time, want, i_noise_value);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_op)
                    OP_EVAL: noise_expected.push_back(noise_at(i_coord_x, i_coord_y));
                    OP_PERM: perm_copy[i_entry_index] = i_perm_value;
                    OP_GRAD: grad_copy[i_entry_index] = '{gx: i_grad_x, gy: i_grad_y};
                    default: ;
                endcase
            end
            o_pending <= noise_expected.size();
        end
    end
endmodule

### test/testbench.sv
module testbench import gn_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int STALL_LIMIT = 4000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_op = OP_NONE;
    logic signed [23:0] i_coord_x = '0;
    logic signed [23:0] i_coord_y = '0;
    logic [7:0]         i_entry_index = '0;
    logic [7:0]         i_perm_value = '0;
    logic signed [15:0] i_grad_x = '0;
    logic signed [15:0] i_grad_y = '0;
    logic               o_valid;
    logic signed [15:0] o_noise_value;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    bit                 burst_mode = 0;

    always #4 i_clk = ~i_clk;

    gradient_noise_2d u_top (.*);

    noise_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_op(i_op), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_entry_index(i_entry_index), .i_perm_value(i_perm_value),
        .i_grad_x(i_grad_x), .i_grad_y(i_grad_y), .i_valid(o_valid),
        .i_noise_value(o_noise_value), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("gradient_noise_2d regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(logic [1:0] op, logic [23:0] cx, logic [23:0] cy,
                                logic [7:0] idx, logic [7:0] pv,
                                logic [15:0] gx, logic [15:0] gy);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op = op;
        i_coord_x = cx;
        i_coord_y = cy;
        i_entry_index = idx;
        i_perm_value = pv;
        i_grad_x = gx;
        i_grad_y = gy;
        start = 1'b1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic eval_at(logic [23:0] cx, logic [23:0] cy);
        send_request(OP_EVAL, cx, cy, 8'($urandom), 8'($urandom), 16'($urandom),
                     16'($urandom));
    endtask

    function automatic logic [15:0] rand_grad();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'sh8000;
        if (r == 1) return 16'sh7FFF;
        if (r == 2) return 16'sd16384;
        if (r == 3) return -16'sd16384;
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic logic [23:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'sh800000 + 24'($urandom_range(0, 3));
        if (r == 1) return 24'sh7FFFFF - 24'($urandom_range(0, 3));
        if (r == 2) return {8'($urandom), 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
        return 24'($urandom);
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < GN_TABLE_SIZE; k++) begin
            send_request(OP_PERM, 24'($urandom), 24'($urandom), 8'(k), 8'($urandom),
                         16'($urandom), 16'($urandom));
            send_request(OP_GRAD, 24'($urandom), 24'($urandom), 8'(k), 8'($urandom),
                         rand_grad(), rand_grad());
        end

        eval_at(24'h000000, 24'h000000);
        eval_at(24'h7FFFFF, 24'h7FFFFF);
        eval_at(24'h800000, 24'h800000);
        eval_at(24'h7FFFFF, 24'h800000);
        eval_at(24'h008000, 24'h008000);
        eval_at(24'h00FFFF, 24'h000001);
        eval_at(24'hFF0000, 24'h00FFFF);
        eval_at(24'hFFFFFF, 24'h010000);
        send_request(OP_NONE, 24'h7FFFFF, 24'h800000, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_NONE, 24'h000000, 24'h000000, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_request(OP_PERM, '0, '0, 8'hFF, 8'hFF, '0, '0);
        send_request(OP_PERM, '0, '0, 8'h00, 8'h00, '0, '0);
        send_request(OP_GRAD, '0, '0, 8'h00, 8'h00, 16'sh7FFF, 16'sh7FFF);
        send_request(OP_GRAD, '0, '0, 8'hFF, 8'hFF, 16'sh8000, 16'sh8000);
        send_request(OP_GRAD, '0, '0, 8'h01, 8'h00, 16'sd16384, -16'sd16384);
        for (int k = 0; k < 8; k++) begin
            eval_at(24'(k * 24'h008000 + 24'hFF0000), 24'(24'h00FFFF - k));
        end

        for (int n = 0; n < 1200; n++) begin
            int r;
            if (n % 150 == 0) burst_mode = ~burst_mode;
            if (n == 600) begin
                @(negedge i_clk);
                start = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                eval_at(rand_coord(), rand_coord());
            end else if (r < 81) begin
                send_request(OP_PERM, 24'($urandom), 24'($urandom), 8'($urandom),
                             8'($urandom), 16'($urandom), 16'($urandom));
            end else if (r < 93) begin
                send_request(OP_GRAD, 24'($urandom), 24'($urandom), 8'($urandom),
                             8'($urandom), rand_grad(), rand_grad());
            end else begin
                send_request(OP_NONE, 24'($urandom), 24'($urandom), 8'($urandom),
                             8'($urandom), 16'($urandom), 16'($urandom));
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("gradient_noise_2d regression: pass");
        end else begin
            $display("gradient_noise_2d regression: fail");
        end
        $finish;
    end
endmodule

### filelist.f
src/gn_pkg.sv
src/gn_fade.sv
src/gn_lattice.sv
src/gn_blend.sv
src/gradient_noise_2d.sv
test/noise_checker.sv
test/testbench.sv
